>>> rtl/bls_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bls_pkg
// Shared types, widths and codes for the line stepper: coordinate, span and
// error widths, the command record that goes through the queue, and the
// pixel record held in the output register.
// ----------------------------------------------------------------------------
package bls_pkg;

    localparam int COORD_BITS     = 12;
    localparam int SPAN_BITS      = COORD_BITS + 1;
    localparam int ERR_BITS       = SPAN_BITS + 2;
    localparam int SCREEN_BITS    = 11;
    localparam int COLOR_BITS     = 8;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CMP_BITS       = (COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS;

    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // Item codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_HEIGHT = CFG_INDEX_BITS'(1);

    localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RESET  = SCREEN_BITS'(640);
    localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RESET = SCREEN_BITS'(400);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic        [SPAN_BITS-1:0]  t_span;
    typedef logic signed [ERR_BITS-1:0]   t_err;

    typedef struct packed {
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
    } t_color;

    // Classified item, as handed from the front end to the back end
    typedef struct packed {
        logic   is_start;
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
        t_span  span_x;
        t_span  span_y;
        logic   x_neg;
        logic   y_neg;
        logic   x_major;
        logic   single;
        t_color color;
    } t_cmd;

    // One result
    typedef struct packed {
        logic   pix_valid;
        t_coord x;
        t_coord y;
        logic   last;
        t_color color;
    } t_pixel;

endpackage : bls_pkg
`default_nettype wire

>>> rtl/bresenham_line_stepper_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bresenham_line_stepper_core
// Integer Bresenham line stepper, all octants, with screen clipping flag.
// ----------------------------------------------------------------------------
// Sustains one item per clock while the output register is free or emptied:
// a start item returns the first pixel, each step item the next pixel, and a
// step with no line active returns an all-zero result. A transferred item is
// written into a slot of the two-entry command queue; once it is at the head
// and the output register is free or emptied, the back end runs its single
// error update and loads the output register, which sets the rate. Input keeps
// flowing while a result waits; it stalls only when the queue is full.
// Screen width and height are written through the plain register port; the user
// must write them only while the block is idle (not enforced); reset 640 by 400.
module bresenham_line_stepper_core (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [bls_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  wire logic [bls_pkg::SCREEN_BITS-1:0]       i_cfg_wdata,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic                                  i_opcode,
    input  wire bls_pkg::t_coord                       i_start_x,
    input  wire bls_pkg::t_coord                       i_start_y,
    input  wire bls_pkg::t_coord                       i_end_x,
    input  wire bls_pkg::t_coord                       i_end_y,
    input  wire logic [bls_pkg::COLOR_BITS-1:0]        i_red_in,
    input  wire logic [bls_pkg::COLOR_BITS-1:0]        i_green_in,
    input  wire logic [bls_pkg::COLOR_BITS-1:0]        i_blue_in,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic                                       o_pixel_valid,
    output bls_pkg::t_coord                            o_pixel_x,
    output bls_pkg::t_coord                            o_pixel_y,
    output logic                                       o_on_screen,
    output logic                                       o_last_pixel,
    output logic [bls_pkg::COLOR_BITS-1:0]             o_red_out,
    output logic [bls_pkg::COLOR_BITS-1:0]             o_green_out,
    output logic [bls_pkg::COLOR_BITS-1:0]             o_blue_out
);
    import bls_pkg::*;

    logic   push;
    logic   queue_full;
    logic   queue_valid;
    logic   pop;
    t_cmd   push_cmd;
    t_cmd   head_cmd;
    t_pixel pixel;

    // Accept and classify
    bls_front u_front (
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    // Decouple front and back
    bls_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_data  (head_cmd)
    );

    // Step the line and hold the result
    bls_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (queue_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pixel     (pixel),
        .o_on_screen (o_on_screen)
    );

    assign o_pixel_valid = pixel.pix_valid;
    assign o_pixel_x     = pixel.x;
    assign o_pixel_y     = pixel.y;
    assign o_last_pixel  = pixel.last;
    assign o_red_out     = pixel.color.red;
    assign o_green_out   = pixel.color.green;
    assign o_blue_out    = pixel.color.blue;

endmodule : bresenham_line_stepper_core
`default_nettype wire

>>> rtl/bls_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bls_front
// Front end: accepts input items while the queue has room and classifies
// them. A start item gets its spans, step directions, major axis and the
// single-point flag worked out here.
// ----------------------------------------------------------------------------
module bls_front (
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_opcode,
    input  wire bls_pkg::t_coord                   i_start_x,
    input  wire bls_pkg::t_coord                   i_start_y,
    input  wire bls_pkg::t_coord                   i_end_x,
    input  wire bls_pkg::t_coord                   i_end_y,
    input  wire logic [bls_pkg::COLOR_BITS-1:0]    i_red_in,
    input  wire logic [bls_pkg::COLOR_BITS-1:0]    i_green_in,
    input  wire logic [bls_pkg::COLOR_BITS-1:0]    i_blue_in,
    input  wire logic                              i_queue_full,
    output logic                                   o_push,
    output bls_pkg::t_cmd                          o_cmd
);
    import bls_pkg::*;

    logic signed [SPAN_BITS-1:0] dx;
    logic signed [SPAN_BITS-1:0] dy;
    t_span                       span_x;
    t_span                       span_y;

    // Accept while the queue has a free slot
    assign o_in_ready = !i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;

    // Signed deltas, one bit wider than a coordinate
    assign dx = {i_end_x[COORD_BITS-1], i_end_x} - {i_start_x[COORD_BITS-1], i_start_x};
    assign dy = {i_end_y[COORD_BITS-1], i_end_y} - {i_start_y[COORD_BITS-1], i_start_y};

    // Absolute spans
    assign span_x = dx[SPAN_BITS-1] ? t_span'(-dx) : t_span'(dx);
    assign span_y = dy[SPAN_BITS-1] ? t_span'(-dy) : t_span'(dy);

    // Build the command record
    always_comb begin
        o_cmd.is_start = (i_opcode == OP_START);
        o_cmd.start_x  = i_start_x;
        o_cmd.start_y  = i_start_y;
        o_cmd.end_x    = i_end_x;
        o_cmd.end_y    = i_end_y;
        o_cmd.span_x   = span_x;
        o_cmd.span_y   = span_y;
        o_cmd.x_neg    = dx[SPAN_BITS-1];
        o_cmd.y_neg    = dy[SPAN_BITS-1];
        o_cmd.x_major  = (span_x >= span_y);
        o_cmd.single   = (span_x == '0) && (span_y == '0);
        o_cmd.color    = '{red: i_red_in, green: i_green_in, blue: i_blue_in};
    end

endmodule : bls_front
`default_nettype wire

>>> rtl/bls_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bls_queue
// Short command queue between front and back end. Register slots, one write
// and one read pointer, and an occupancy count.
// ----------------------------------------------------------------------------
module bls_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire bls_pkg::t_cmd i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output bls_pkg::t_cmd      o_data
);
    import bls_pkg::*;

    t_cmd                      r_slot [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wr_ptr;
    logic [QUEUE_PTR_BITS-1:0] n_wr_ptr;
    logic [QUEUE_PTR_BITS-1:0] r_rd_ptr;
    logic [QUEUE_PTR_BITS-1:0] n_rd_ptr;
    logic [QUEUE_CNT_BITS-1:0] r_count;
    logic [QUEUE_CNT_BITS-1:0] n_count;
    logic                      do_push;
    logic                      do_pop;

    assign o_full  = (r_count == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Advance pointers with wrap, track occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store pushed command
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
        else $error("queue occupancy beyond depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
`endif

endmodule : bls_queue
`default_nettype wire

>>> rtl/bls_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bls_back
// Back end: holds the line state and the screen registers, runs one
// Bresenham error update per command and loads the output register.
// ----------------------------------------------------------------------------
module bls_back (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [bls_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  wire logic [bls_pkg::SCREEN_BITS-1:0]       i_cfg_wdata,
    input  wire logic                                  i_cmd_valid,
    input  wire bls_pkg::t_cmd                         i_cmd,
    output logic                                       o_pop,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output bls_pkg::t_pixel                            o_pixel,
    output logic                                       o_on_screen
);
    import bls_pkg::*;

    // Screen registers
    logic [SCREEN_BITS-1:0] r_width;
    logic [SCREEN_BITS-1:0] r_height;

    // Line state
    logic   r_active;
    logic   n_active;
    t_coord r_cur_x;
    t_coord n_cur_x;
    t_coord r_cur_y;
    t_coord n_cur_y;
    t_coord r_tgt_x;
    t_coord n_tgt_x;
    t_coord r_tgt_y;
    t_coord n_tgt_y;
    t_span  r_span_x;
    t_span  n_span_x;
    t_span  r_span_y;
    t_span  n_span_y;
    t_err   r_err;
    t_err   n_err;
    logic   r_x_major;
    logic   n_x_major;
    logic   r_x_neg;
    logic   n_x_neg;
    logic   r_y_neg;
    logic   n_y_neg;
    t_color r_color;
    t_color n_color;

    // Output register
    logic   r_out_valid;
    t_pixel r_out;
    t_pixel n_out;

    logic   fire;
    t_span  major;
    t_span  minor;
    t_span  init_major;
    t_span  init_minor;
    logic   diag;
    logic   move_x;
    logic   move_y;
    t_coord step_x;
    t_coord step_y;
    t_err   err_axial;
    t_err   err_diag;
    logic   step_last;

    // Take a command when the output slot is free or being emptied
    assign fire  = i_cmd_valid && (!r_out_valid || i_out_ready);
    assign o_pop = fire;

    // Error update for a step
    assign major     = r_x_major ? r_span_x : r_span_y;
    assign minor     = r_x_major ? r_span_y : r_span_x;
    assign diag      = !r_err[ERR_BITS-1];
    assign move_x    = r_x_major || diag;
    assign move_y    = !r_x_major || diag;
    assign err_axial = t_err'({1'b0, minor, 1'b0});
    assign err_diag  = t_err'({1'b0, minor, 1'b0}) - t_err'({1'b0, major, 1'b0});
    assign step_x    = move_x ? (r_cur_x + (r_x_neg ? t_coord'(-1) : t_coord'(1))) : r_cur_x;
    assign step_y    = move_y ? (r_cur_y + (r_y_neg ? t_coord'(-1) : t_coord'(1))) : r_cur_y;
    assign step_last = r_x_major ? (step_x == r_tgt_x) : (step_y == r_tgt_y);

    // Initial error for a start
    assign init_major = i_cmd.x_major ? i_cmd.span_x : i_cmd.span_y;
    assign init_minor = i_cmd.x_major ? i_cmd.span_y : i_cmd.span_x;

    // Next line state and result
    always_comb begin
        n_active  = r_active;
        n_cur_x   = r_cur_x;
        n_cur_y   = r_cur_y;
        n_tgt_x   = r_tgt_x;
        n_tgt_y   = r_tgt_y;
        n_span_x  = r_span_x;
        n_span_y  = r_span_y;
        n_err     = r_err;
        n_x_major = r_x_major;
        n_x_neg   = r_x_neg;
        n_y_neg   = r_y_neg;
        n_color   = r_color;
        n_out     = '0;
        if (i_cmd.is_start) begin
            n_cur_x   = i_cmd.start_x;
            n_cur_y   = i_cmd.start_y;
            n_tgt_x   = i_cmd.end_x;
            n_tgt_y   = i_cmd.end_y;
            n_span_x  = i_cmd.span_x;
            n_span_y  = i_cmd.span_y;
            n_x_major = i_cmd.x_major;
            n_x_neg   = i_cmd.x_neg;
            n_y_neg   = i_cmd.y_neg;
            n_color   = i_cmd.color;
            n_err     = t_err'({1'b0, init_minor, 1'b0}) - t_err'({2'b00, init_major});
            n_active  = !i_cmd.single;
            n_out     = '{pix_valid: 1'b1, x: i_cmd.start_x, y: i_cmd.start_y,
                          last: i_cmd.single, color: i_cmd.color};
        end else if (r_active) begin
            n_cur_x  = step_x;
            n_cur_y  = step_y;
            n_err    = r_err + (diag ? err_diag : err_axial);
            n_active = !step_last;
            n_out    = '{pix_valid: 1'b1, x: step_x, y: step_y,
                         last: step_last, color: r_color};
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            r_width     <= SCREEN_WIDTH_RESET;
            r_height    <= SCREEN_HEIGHT_RESET;
        end else begin
            if (fire) begin
                r_active <= n_active;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SCREEN_WIDTH:  r_width  <= i_cfg_wdata;
                    CFG_SCREEN_HEIGHT: r_height <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Payload state
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_cur_x   <= n_cur_x;
            r_cur_y   <= n_cur_y;
            r_tgt_x   <= n_tgt_x;
            r_tgt_y   <= n_tgt_y;
            r_span_x  <= n_span_x;
            r_span_y  <= n_span_y;
            r_err     <= n_err;
            r_x_major <= n_x_major;
            r_x_neg   <= n_x_neg;
            r_y_neg   <= n_y_neg;
            r_color   <= n_color;
            r_out     <= n_out;
        end
    end

    // Clip against the screen
    assign o_out_valid = r_out_valid;
    assign o_pixel     = r_out;
    assign o_on_screen = r_out.pix_valid
                      && !r_out.x[COORD_BITS-1] && !r_out.y[COORD_BITS-1]
                      && (CMP_BITS'($unsigned(r_out.x)) < CMP_BITS'(r_width))
                      && (CMP_BITS'($unsigned(r_out.y)) < CMP_BITS'(r_height));

`ifndef ASSERT_OFF
    a_fire_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("output register not loaded after command");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && n_out.last) |=> !r_active)
        else $error("line still active after last pixel");

    a_active_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_x_major ? (r_cur_x != r_tgt_x) : (r_cur_y != r_tgt_y)))
        else $error("active line already at its end point");
`endif

endmodule : bls_back
`default_nettype wire

>>> tb/tb_bresenham_line_stepper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bresenham_line_stepper
// Self-checking bench for the line stepper core. A behavioral tracer mirrors
// the Bresenham state and predicts one pixel per transferred item. A checker
// compares every output transfer field by field. Stimulus runs in phases:
// directed lines (several octants, single point, extremes, an abandoned line,
// idle steps), sweeps over screen sizes including zero and full range, random
// lines with random stalls on both sides, and long output holds that back the
// block up to its input.
// ----------------------------------------------------------------------------
module tb;
    import bls_pkg::*;

    typedef struct packed {
        logic   pix_valid;
        t_coord x;
        t_coord y;
        logic   on_screen;
        logic   last;
        t_color color;
    } t_pixel_rec;

    // DUT ports
    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [SCREEN_BITS-1:0]    i_cfg_wdata = '0;
    logic                      i_in_valid  = 1'b0;
    logic                      o_in_ready;
    logic                      i_opcode    = OP_START;
    t_coord                    i_start_x   = '0;
    t_coord                    i_start_y   = '0;
    t_coord                    i_end_x     = '0;
    t_coord                    i_end_y     = '0;
    logic [COLOR_BITS-1:0]     i_red_in    = '0;
    logic [COLOR_BITS-1:0]     i_green_in  = '0;
    logic [COLOR_BITS-1:0]     i_blue_in   = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic                      o_pixel_valid;
    t_coord                    o_pixel_x;
    t_coord                    o_pixel_y;
    logic                      o_on_screen;
    logic                      o_last_pixel;
    logic [COLOR_BITS-1:0]     o_red_out;
    logic [COLOR_BITS-1:0]     o_green_out;
    logic [COLOR_BITS-1:0]     o_blue_out;

    // Tracer state: mirror of the stepper
    logic                   ln_active  = 1'b0;
    t_coord                 pos_x      = '0;
    t_coord                 pos_y      = '0;
    t_coord                 tgt_x      = '0;
    t_coord                 tgt_y      = '0;
    t_span                  run_x      = '0;
    t_span                  run_y      = '0;
    t_err                   err_acc    = '0;
    logic                   major_is_x = 1'b0;
    logic                   x_dec      = 1'b0;
    logic                   y_dec      = 1'b0;
    t_color                 ln_color   = '0;
    logic [SCREEN_BITS-1:0] screen_w   = SCREEN_WIDTH_RESET;
    logic [SCREEN_BITS-1:0] screen_h   = SCREEN_HEIGHT_RESET;

    t_pixel_rec expected_pixels[$];

    // Bench control and statistics
    bit source_jitter = 1'b1;
    bit sink_jitter   = 1'b1;
    int hold_request  = 0;
    int hold_left     = 0;
    int stall_left    = 0;
    int items_sent    = 0;
    int mismatches    = 0;
    int lines_started = 0;
    int lines_ended   = 0;
    int idle_steps    = 0;
    int pixels_on     = 0;
    int input_stalls  = 0;

    bresenham_line_stepper_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pixel_valid(o_pixel_valid),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_on_screen  (o_on_screen),
        .o_last_pixel (o_last_pixel),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out)
    );

    always #10 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_coord clamp_coord(input int v);
        int lo;
        int hi;
        lo = -(1 << (COORD_BITS - 1));
        hi = (1 << (COORD_BITS - 1)) - 1;
        if (v < lo) return t_coord'(lo);
        if (v > hi) return t_coord'(hi);
        return t_coord'(v);
    endfunction

    // Advance the tracer by one item and return the pixel it yields
    function automatic t_pixel_rec trace_next(input logic op, input t_coord sx, input t_coord sy,
                                              input t_coord ex, input t_coord ey,
                                              input t_color col);
        t_pixel_rec px;
        int         dx;
        int         dy;
        int         major;
        int         minor;
        logic       diag;
        logic       done;
        px = '0;
        if (op == OP_START) begin
            dx         = int'(ex) - int'(sx);
            dy         = int'(ey) - int'(sy);
            x_dec      = dx < 0;
            y_dec      = dy < 0;
            run_x      = t_span'(x_dec ? -dx : dx);
            run_y      = t_span'(y_dec ? -dy : dy);
            pos_x      = sx;
            pos_y      = sy;
            tgt_x      = ex;
            tgt_y      = ey;
            major_is_x = run_x >= run_y;
            err_acc    = major_is_x ? t_err'(2 * int'(run_y) - int'(run_x))
                                    : t_err'(2 * int'(run_x) - int'(run_y));
            ln_color   = col;
            lines_started++;
        end else if (!ln_active) begin
            idle_steps++;
            return px;
        end else begin
            major = major_is_x ? int'(run_x) : int'(run_y);
            minor = major_is_x ? int'(run_y) : int'(run_x);
            diag  = err_acc >= 0;
            if (major_is_x || diag) pos_x = t_coord'(int'(pos_x) + (x_dec ? -1 : 1));
            if (!major_is_x || diag) pos_y = t_coord'(int'(pos_y) + (y_dec ? -1 : 1));
            err_acc = t_err'(int'(err_acc) + (diag ? 2 * (minor - major) : 2 * minor));
        end
        done      = major_is_x ? (pos_x == tgt_x) : (pos_y == tgt_y);
        ln_active = !done;
        px.pix_valid = 1'b1;
        px.x         = pos_x;
        px.y         = pos_y;
        px.on_screen = pos_x >= 0 && int'(pos_x) < int'(screen_w) &&
                       pos_y >= 0 && int'(pos_y) < int'(screen_h);
        px.last      = done;
        px.color     = ln_color;
        if (done) lines_ended++;
        if (px.on_screen) pixels_on++;
        return px;
    endfunction

    // Predict at every input transfer; count cycles the block holds off the sender
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid) begin
            if (o_in_ready)
                expected_pixels.push_back(trace_next(i_opcode, i_start_x, i_start_y,
                                                     i_end_x, i_end_y,
                                                     t_color'({i_red_in, i_green_in,
                                                               i_blue_in})));
            else
                input_stalls++;
        end
    end

    task automatic check_field(input string name, input logic signed [31:0] expv,
                               input logic signed [31:0] actv);
        if (actv !== expv) begin
            $error("%s: expected %0d, got %0d", name, expv, actv);
            mismatches++;
        end
    endtask

    // Compare each output transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_pixel_rec want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_pixels.size() == 0) begin
                $error("pixel transfer with no prediction pending");
                mismatches++;
            end else begin
                want = expected_pixels.pop_front();
                check_field("pixel_valid", want.pix_valid, o_pixel_valid);
                check_field("pixel_x", want.x, o_pixel_x);
                check_field("pixel_y", want.y, o_pixel_y);
                check_field("on_screen", want.on_screen, o_on_screen);
                check_field("last_pixel", want.last, o_last_pixel);
                check_field("red_out", want.color.red, o_red_out);
                check_field("green_out", want.color.green, o_green_out);
                check_field("blue_out", want.color.blue, o_blue_out);
            end
        end
    end

    // Pixel sink: long holds on request, otherwise random stalls
    always @(posedge i_clk) begin
        int gap;
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (sink_jitter && $urandom_range(0, 99) < 20) begin
            gap         = pick_gap();
            stall_left  = (gap > 0) ? gap - 1 : 0;
            i_out_ready <= (gap == 0);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Offer one item and hold it until the transfer
    task automatic send_item(input logic op, input t_coord sx, input t_coord sy,
                             input t_coord ex, input t_coord ey, input t_color col);
        int gap;
        gap = source_jitter ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_start_x  <= sx;
        i_start_y  <= sy;
        i_end_x    <= ex;
        i_end_y    <= ey;
        i_red_in   <= col.red;
        i_green_in <= col.green;
        i_blue_in  <= col.blue;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        items_sent++;
    endtask

    // Step with junk in the unused fields
    task automatic send_step();
        send_item(OP_STEP, t_coord'($urandom), t_coord'($urandom), t_coord'($urandom),
                  t_coord'($urandom), t_color'($urandom));
    endtask

    // Drop valid and wait until every predicted pixel has been transferred
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_screen_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                                    input logic [SCREEN_BITS-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SCREEN_WIDTH) screen_w = val;
        else screen_h = val;
    endtask

    task automatic set_screen(input int w, input int h);
        wait_drained();
        write_screen_reg(CFG_SCREEN_WIDTH, SCREEN_BITS'(w));
        write_screen_reg(CFG_SCREEN_HEIGHT, SCREEN_BITS'(h));
    endtask

    // One line with random content: mostly run to the end, some overrun, some cut short
    task automatic random_line();
        int     mode;
        int     sx;
        int     sy;
        int     ox;
        int     oy;
        int     spread;
        int     major;
        int     nsteps;
        int     r;
        t_coord csx;
        t_coord csy;
        t_coord cex;
        t_coord cey;
        mode   = $urandom_range(0, 99);
        sx     = int'(t_coord'($urandom));
        sy     = int'(t_coord'($urandom));
        spread = $urandom_range(1, 12);
        if (mode >= 40 && mode < 75) begin
            // place the line around a screen edge
            r  = $urandom_range(0, 2);
            sx = (r == 0) ? 0 : (r == 1) ? int'(screen_w) : int'($urandom_range(0, screen_w));
            r  = $urandom_range(0, 2);
            sy = (r == 0) ? 0 : (r == 1) ? int'(screen_h) : int'($urandom_range(0, screen_h));
            sx = sx + int'($urandom_range(0, 12)) - 6;
            sy = sy + int'($urandom_range(0, 12)) - 6;
            spread = $urandom_range(1, 16);
        end else if (mode >= 75 && mode < 82) begin
            spread = $urandom_range(20, 120);
        end
        ox = int'($urandom_range(0, 2 * spread)) - spread;
        oy = int'($urandom_range(0, 2 * spread)) - spread;
        if (mode >= 82 && mode < 93) begin
            // axis-aligned or exact diagonal
            spread = $urandom_range(1, 20);
            ox     = (int'($urandom_range(0, 2)) - 1) * spread;
            oy     = (int'($urandom_range(0, 2)) - 1) * spread;
        end else if (mode >= 93) begin
            ox = 0;
            oy = 0;
        end
        csx   = clamp_coord(sx);
        csy   = clamp_coord(sy);
        cex   = clamp_coord(int'(csx) + ox);
        cey   = clamp_coord(int'(csy) + oy);
        ox    = int'(cex) - int'(csx);
        oy    = int'(cey) - int'(csy);
        ox    = (ox < 0) ? -ox : ox;
        oy    = (oy < 0) ? -oy : oy;
        major = (ox > oy) ? ox : oy;
        r     = $urandom_range(0, 99);
        if (r < 80) nsteps = major;
        else if (r < 90) nsteps = major + $urandom_range(1, 3);
        else nsteps = (major == 0) ? 0 : $urandom_range(0, major - 1);
        send_item(OP_START, csx, csy, cex, cey, t_color'($urandom));
        repeat (nsteps) send_step();
    endtask

    task automatic random_lines(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) random_line();
    endtask

    // Idle step, single point, extremes, abandoned line, screen edge, octants
    task automatic test_directed();
        send_step();
        send_item(OP_START, 5, 5, 5, 5, t_color'{8'h12, 8'h34, 8'h56});
        send_step();
        send_item(OP_START, -2048, -2048, 2047, 2047, t_color'{8'hFF, 8'hFF, 8'hFF});
        send_step();
        send_item(OP_START, 2047, -2048, 2045, -2046, t_color'{8'h00, 8'h00, 8'h00});
        repeat (2) send_step();
        send_item(OP_START, 638, 398, 641, 400, t_color'{8'hA5, 8'h5A, 8'hC3});
        repeat (3) send_step();
        send_item(OP_START, -1, -1, 0, 1, t_color'{8'h01, 8'h80, 8'h7F});
        repeat (2) send_step();
        send_item(OP_START, 3, 0, 0, -3, t_color'{8'hFE, 8'h02, 8'h40});
        repeat (3) send_step();
        send_item(OP_START, 0, 2, -1, 0, t_color'{8'h33, 8'hCC, 8'h99});
        repeat (2) send_step();
        send_step();
    endtask

    // Sweep screen sizes: smallest, full range, zero, mixed, random
    task automatic test_screen_settings();
        int widths[5];
        int heights[5];
        widths  = '{1, 2047, 0, 2047, 0};
        heights = '{1, 2047, 0, 1, 2047};
        for (int k = 0; k < 5; k++) begin
            set_screen(widths[k], heights[k]);
            random_lines(120);
        end
        set_screen($urandom_range(1, 2047), $urandom_range(1, 2047));
        random_lines(120);
    endtask

    // Back at the reset screen: jittered traffic, then a stretch at full rate
    task automatic test_random_traffic();
        set_screen(SCREEN_WIDTH_RESET, SCREEN_HEIGHT_RESET);
        random_lines(650);
        wait_drained();
        source_jitter = 1'b0;
        sink_jitter   = 1'b0;
        random_lines(200);
        source_jitter = 1'b1;
        sink_jitter   = 1'b1;
    endtask

    // Hold the sink for long stretches while the sender keeps offering
    task automatic test_output_backpressure();
        wait_drained();
        source_jitter = 1'b0;
        hold_request  = 150;
        random_lines(90);
        hold_request  = 60;
        random_lines(90);
        source_jitter = 1'b1;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_screen_settings();
        test_random_traffic();
        test_output_backpressure();
        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("Ran %0d items: %0d lines started, %0d reached their end point, %0d idle steps",
                 items_sent, lines_started, lines_ended, idle_steps);
        $display("%0d pixels on screen over 7 screen sizes, %0d cycles of input held off",
                 pixels_on, input_stalls);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog
    initial begin
        #40_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> bresenham_line_stepper_core.f
rtl/bls_pkg.sv
rtl/bls_front.sv
rtl/bls_queue.sv
rtl/bls_back.sv
rtl/bresenham_line_stepper_core.sv
tb/tb_bresenham_line_stepper.sv
